>>> rtl/core/wpn_pkg.sv
package wpn_pkg;

  localparam int unsigned InW    = 24;
  localparam int unsigned WgtW   = 16;
  localparam int unsigned EpsW   = 23;
  localparam int unsigned OutW   = 16;
  localparam int unsigned SqW    = 64;
  localparam int unsigned SqSteps = 32;
  localparam int unsigned QW     = 17;
  localparam int unsigned RemW   = 51;
  localparam int unsigned YW     = 34;
  localparam int unsigned NW     = 48;

  // carried through the square root stages
  typedef struct packed {
    logic [SqW-1:0] rem;
    logic [SqW-1:0] res;
    logic [NW-1:0]  n_re;
    logic [NW-1:0]  n_im;
    logic           neg_re;
    logic           neg_im;
    logic           fe;
  } wpn_sq_t;

  // carried through the divider stages
  typedef struct packed {
    logic [YW-1:0]   y;
    logic [RemW-1:0] rem_re;
    logic [RemW-1:0] rem_im;
    logic [QW-1:0]   q_re;
    logic [QW-1:0]   q_im;
    logic            ovf_re;
    logic            ovf_im;
    logic            zero;
    logic            neg_re;
    logic            neg_im;
    logic            fe;
  } wpn_dv_t;

endpackage

>>> rtl/core/weighted_phasor_normalize.sv
// path: magnitude stage, root-format stage, root stages, divider setup, divider stages, output register
// throughput: one bin per cycle unless the output stalls; 32 root stages and 17 divider stages
// a stall at the output holds the whole pipeline in place
// reset: all stage valid bits clear, epsilon returns to 1
module weighted_phasor_normalize import wpn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [InW-1:0]  re_in_i,
  input  logic signed [InW-1:0]  im_in_i,
  input  logic [WgtW-1:0]        bin_weight_i,
  input  logic                   frame_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] re_out_o,
  output logic signed [OutW-1:0] im_out_o,
  output logic                   frame_end_out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [EpsW-1:0]        cfg_data_i
);

  logic adv;
  logic [EpsW-1:0] eps_q;

  // pipeline moves unless the result is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsW'(1);
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // stage 1: magnitudes and products
  logic [InW-1:0] are, aim;
  logic v1_q;
  logic [NW-1:0] sqre_q, sqim_q;
  logic [InW+WgtW-1:0] pre_q, pim_q;
  logic nre1_q, nim1_q, fe1_q;

  assign are = re_in_i[InW-1] ? InW'(-re_in_i) : InW'(re_in_i);
  assign aim = im_in_i[InW-1] ? InW'(-im_in_i) : InW'(im_in_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqre_q <= NW'(are) * NW'(are);
      sqim_q <= NW'(aim) * NW'(aim);
      pre_q  <= (InW+WgtW)'(are) * (InW+WgtW)'(bin_weight_i);
      pim_q  <= (InW+WgtW)'(aim) * (InW+WgtW)'(bin_weight_i);
      nre1_q <= re_in_i[InW-1];
      nim1_q <= im_in_i[InW-1];
      fe1_q  <= frame_end_i;
    end
  end

  // stage 2: squared magnitude into root format, weighted products scaled
  logic    v2_q;
  wpn_sq_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.rem    <= SqW'(sqre_q + sqim_q) << 16;
      s2_q.res    <= '0;
      s2_q.n_re   <= NW'(pre_q) << 8;
      s2_q.n_im   <= NW'(pim_q) << 8;
      s2_q.neg_re <= nre1_q;
      s2_q.neg_im <= nim1_q;
      s2_q.fe     <= fe1_q;
    end
  end

  // square root stages
  logic    sv [SqSteps+1];
  wpn_sq_t sd [SqSteps+1];

  assign sv[0] = v2_q;
  assign sd[0] = s2_q;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    wpn_sqrt_step #(.Step(k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[k]),
      .data_i  (sd[k]),
      .valid_o (sv[k+1]),
      .data_o  (sd[k+1])
    );
  end

  // denominator, dividends and range check
  logic    vd_q;
  wpn_dv_t dd_q, dd_d;
  logic [YW-2:0] den;
  logic [RemW-1:0] xre, xim, ylim;

  always_comb begin
    den  = (YW-1)'(sd[SqSteps].res[31:0]) + (YW-1)'({eps_q, 8'b0});
    xre  = (RemW'(sd[SqSteps].n_re) << 1) + RemW'(den);
    xim  = (RemW'(sd[SqSteps].n_im) << 1) + RemW'(den);
    ylim = RemW'({den, 1'b0}) << QW;
    dd_d.y      = {den, 1'b0};
    dd_d.rem_re = xre;
    dd_d.rem_im = xim;
    dd_d.q_re   = '0;
    dd_d.q_im   = '0;
    dd_d.ovf_re = (xre >= ylim);
    dd_d.ovf_im = (xim >= ylim);
    dd_d.zero   = (den == '0);
    dd_d.neg_re = sd[SqSteps].neg_re;
    dd_d.neg_im = sd[SqSteps].neg_im;
    dd_d.fe     = sd[SqSteps].fe;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= sv[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q <= dd_d;
    end
  end

  // divider stages, most significant quotient bit first
  logic    dv [QW+1];
  wpn_dv_t dx [QW+1];

  assign dv[0] = vd_q;
  assign dx[0] = dd_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    wpn_div_step #(.Step(QW - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[k]),
      .data_i  (dx[k]),
      .valid_o (dv[k+1]),
      .data_o  (dx[k+1])
    );
  end

  // saturation and sign into the output register
  function automatic logic [OutW-1:0] wpn_sat(input logic [QW-1:0] q, input logic ovf,
                                             input logic neg, input logic zero);
    logic [OutW-1:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      if (ovf || q > QW'(32768)) r = 16'h8000;
      else r = OutW'(-q);
    end else begin
      if (ovf || q > QW'(32767)) r = 16'h7fff;
      else r = OutW'(q);
    end
    return r;
  endfunction

  logic out_v_q;
  logic [OutW-1:0] re_q, im_q;
  logic fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q <= wpn_sat(dx[QW].q_re, dx[QW].ovf_re, dx[QW].neg_re, dx[QW].zero);
      im_q <= wpn_sat(dx[QW].q_im, dx[QW].ovf_im, dx[QW].neg_im, dx[QW].zero);
      fe_q <= dx[QW].fe;
    end
  end

  assign out_valid_o     = out_v_q;
  assign re_out_o        = re_q;
  assign im_out_o        = im_q;
  assign frame_end_out_o = fe_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_result_leaves_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");
`endif

endmodule

>>> rtl/core/wpn_sqrt_step.sv
module wpn_sqrt_step import wpn_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  wpn_sq_t data_i,
  output logic    valid_o,
  output wpn_sq_t data_o
);

  localparam logic [SqW-1:0] Bit = SqW'(1) << (62 - 2 * Step);

  logic    valid_q;
  wpn_sq_t data_d, data_q;
  logic [SqW-1:0] trial;

  // one root digit per stage
  always_comb begin
    data_d = data_i;
    trial  = data_i.res + Bit;
    if (data_i.rem >= trial) begin
      data_d.rem = data_i.rem - trial;
      data_d.res = (data_i.res >> 1) + Bit;
    end else begin
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/wpn_div_step.sv
module wpn_div_step import wpn_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  wpn_dv_t data_i,
  output logic    valid_o,
  output wpn_dv_t data_o
);

  logic    valid_q;
  wpn_dv_t data_d, data_q;
  logic [RemW-1:0] ys;

  // one quotient bit per stage on both lanes
  always_comb begin
    data_d = data_i;
    ys     = RemW'(data_i.y) << Step;
    if (data_i.rem_re >= ys) begin
      data_d.rem_re     = data_i.rem_re - ys;
      data_d.q_re[Step] = 1'b1;
    end
    if (data_i.rem_im >= ys) begin
      data_d.rem_im     = data_i.rem_im - ys;
      data_d.q_im[Step] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
